@@ hdl/vtsc_pkg.sv @@
`default_nettype none

package vtsc_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 24;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned AW      = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);

  // Fixed field widths
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(8'h20);
  localparam logic [7:0]        ADDR_XOR   = 8'h60;

  // Operation codes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Received byte codes
  localparam logic [7:0] B_NUL   = 8'h00;
  localparam logic [7:0] B_HOME  = 8'h02;
  localparam logic [7:0] B_BEL   = 8'h07;
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_FF    = 8'h0C;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_INS   = 8'h10;
  localparam logic [7:0] B_EOL   = 8'h17;
  localparam logic [7:0] B_MCLR  = 8'h18;
  localparam logic [7:0] B_CLR1  = 8'h19;
  localparam logic [7:0] B_UP    = 8'h1A;
  localparam logic [7:0] B_RIGHT = 8'h1C;
  localparam logic [7:0] B_ROLL  = 8'h1D;
  localparam logic [7:0] B_CLR2  = 8'h1E;
  localparam logic [7:0] B_DEL   = 8'h7F;

  // Cursor addressing phases
  typedef enum logic [1:0] {
    ADDR_NONE = 2'd0,
    ADDR_COL  = 2'd1,
    ADDR_ROW  = 2'd2
  } addr_phase_e;

endpackage

`default_nettype wire

@@ hdl/video_terminal_screen_controller.sv @@
`default_nettype none

// Character-cell terminal screen controller. Each item either receives one byte
// (operation 0) or reads one cell (operation 1) and gives exactly one result
// with the cursor and mode flags after the item. The 80x24 screen lives in a
// RAM with one write port and one registered read port; cell moves run as a
// read/write-back sequencer, one cell per cycle. A stalled result keeps the next
// item waiting in its done state until the output register is free. The block
// takes one item at a time. After reset a clearing pass writes spaces to all
// 1920 cells, and the first item is accepted only once that pass is done.
module video_terminal_screen_controller
  import vtsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [CHAR_W-1:0] cell_char_o,
  output logic      [COL_W-1:0]  cursor_col_o,
  output logic      [ROW_W-1:0]  cursor_row_o,
  output logic                   insert_mode_on_o,
  output logic                   roll_mode_on_o,
  output logic                   addressing_busy_o
);

  typedef enum logic [1:0] {
    OFF_P1,
    OFF_M1,
    OFF_PC,
    OFF_MC
  } off_e;

  // One memory job: copy run, then fill run, then an optional single write
  typedef struct packed {
    off_e              off;
    logic [AW-1:0]     cdst;
    logic [CNT_W-1:0]  ncopy;
    logic [AW-1:0]     fdst;
    logic [CNT_W-1:0]  nfill;
    logic              put;
    logic [AW-1:0]     paddr;
    logic [CHAR_W-1:0] pval;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_COPY,
    S_FILL,
    S_PUT,
    S_DONE
  } state_e;

  localparam logic signed [9:0] COLS_S = 10'(COLUMNS);
  localparam logic signed [9:0] ROWS_S = 10'(ROWS);

  state_e            state_q, state_d;
  job_t              act_q, act_d;
  job_t              jobb_q, jobb_d;
  logic              jobb_v_q, jobb_v_d;
  logic              emit_q, emit_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wr_pend_q, wr_pend_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              rd_ok_q, rd_ok_d;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic              pcr_q, pcr_d;
  logic              roll_q, roll_d;
  logic              ins_q, ins_d;
  addr_phase_e       phase_q, phase_d;
  logic [7:0]        pend_q, pend_d;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic              out_ins_q, out_ins_d;
  logic              out_roll_q, out_roll_d;
  logic              out_busy_q, out_busy_d;
  logic [CHAR_W-1:0] res_char_q, res_char_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Byte decode results
  job_t              ja, jb;
  logic              jb_v;
  logic              lo_open, lo_close;
  logic [ROW_W-1:0]  lo_row;
  logic signed [9:0] col_v, row_v;
  logic              n_pcr, n_roll, n_ins, do_edge;
  addr_phase_e       n_phase;
  logic [7:0]        n_pend, bx;
  logic [AW-1:0]     rowbase, cpos, rd_addr;
  logic              rd_ok;

  vtsc_ram #(
    .Width(CHAR_W),
    .Depth(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Decode one received byte against the current cursor and modes
  always_comb begin
    ja       = '0;
    jb       = '0;
    jb_v     = 1'b0;
    lo_open  = 1'b0;
    lo_close = 1'b0;
    lo_row   = '0;
    col_v    = 10'(cur_col_q);
    row_v    = 10'(cur_row_q);
    n_pcr    = pcr_q;
    n_roll   = roll_q;
    n_ins    = ins_q;
    n_phase  = phase_q;
    n_pend   = pend_q;
    do_edge  = 1'b1;
    bx       = rx_byte_i ^ ADDR_XOR;
    rowbase  = AW'(cur_row_q) * AW'(COLUMNS);
    cpos     = rowbase + AW'(cur_col_q);

    if (phase_q == ADDR_COL) begin
      n_pend  = bx;
      n_phase = ADDR_ROW;
      do_edge = 1'b0;
    end else if (phase_q == ADDR_ROW) begin
      col_v   = 10'(pend_q);
      row_v   = 10'(bx);
      n_phase = ADDR_NONE;
      n_pcr   = 1'b0;
    end else begin
      n_pcr = (rx_byte_i == B_CR);
      unique case (rx_byte_i)
        B_NUL, B_DEL, B_BEL: begin
        end
        B_BS: begin
          if (ins_q) begin
            ja.off   = OFF_P1;
            ja.cdst  = cpos;
            ja.ncopy = CNT_W'(COLUMNS - 1) - CNT_W'(cur_col_q);
            ja.fdst  = rowbase + AW'(COLUMNS - 1);
            ja.nfill = CNT_W'(1);
          end else begin
            col_v = col_v - 10'sd1;
          end
        end
        B_TAB: begin
          col_v = (col_v + 10'sd8) & ~10'sd7;
        end
        B_FF: begin
          n_phase = ADDR_COL;
          n_pcr   = pcr_q;
          do_edge = 1'b0;
        end
        B_CR, B_LF: begin
          if (rx_byte_i == B_CR) begin
            col_v = '0;
          end
          if (ins_q) begin
            lo_open = 1'b1;
            lo_row  = cur_row_q;
          end else if (!pcr_q) begin
            row_v = row_v + 10'sd1;
          end
        end
        B_EOL: begin
          ja.fdst  = cpos;
          ja.nfill = CNT_W'(COLUMNS) - CNT_W'(cur_col_q);
        end
        B_CLR1, B_CLR2: begin
          ja.fdst  = '0;
          ja.nfill = CNT_W'(CELLS);
          col_v    = '0;
          row_v    = '0;
        end
        B_HOME: begin
          col_v = '0;
          row_v = '0;
        end
        B_INS: begin
          n_ins = 1'b1;
        end
        B_MCLR: begin
          n_roll = 1'b0;
          n_ins  = 1'b0;
        end
        B_UP: begin
          if (ins_q) begin
            lo_close = 1'b1;
            lo_row   = cur_row_q;
          end else begin
            row_v = row_v - 10'sd1;
          end
        end
        B_RIGHT: begin
          if (ins_q) begin
            ja.off   = OFF_M1;
            ja.cdst  = rowbase + AW'(COLUMNS - 1);
            ja.ncopy = CNT_W'(COLUMNS - 1) - CNT_W'(cur_col_q);
            ja.fdst  = cpos;
            ja.nfill = CNT_W'(1);
          end else begin
            col_v = col_v + 10'sd1;
          end
        end
        B_ROLL: begin
          n_roll = 1'b1;
        end
        default: begin
          if (ins_q) begin
            ja.off   = OFF_M1;
            ja.cdst  = rowbase + AW'(COLUMNS - 1);
            ja.ncopy = CNT_W'(COLUMNS - 1) - CNT_W'(cur_col_q);
          end
          ja.put   = 1'b1;
          ja.paddr = cpos;
          ja.pval  = rx_byte_i[CHAR_W-1:0];
          col_v    = col_v + 10'sd1;
        end
      endcase
    end

    // Resolve edges: wrap, saturate, roll or return to top
    if (do_edge) begin
      if (col_v < 10'sd0) begin
        col_v = '0;
      end
      if (col_v >= COLS_S) begin
        col_v = '0;
        if (n_ins) begin
          if (row_v >= 10'sd0 && row_v < ROWS_S) begin
            lo_open = 1'b1;
            lo_row  = row_v[ROW_W-1:0];
          end
        end else if (!n_pcr) begin
          row_v = row_v + 10'sd1;
        end
      end
      if (row_v < 10'sd0) begin
        row_v = '0;
      end
      if (row_v >= ROWS_S) begin
        if (n_roll) begin
          lo_close = 1'b1;
          lo_row   = '0;
          row_v    = ROWS_S - 10'sd1;
        end else begin
          row_v = '0;
        end
      end
    end

    // Line insert or delete job
    if (lo_open) begin
      jb_v     = 1'b1;
      jb.off   = OFF_MC;
      jb.cdst  = AW'(CELLS - 1);
      jb.ncopy = CNT_W'((CNT_W'(ROWS - 1) - CNT_W'(lo_row)) * CNT_W'(COLUMNS));
      jb.fdst  = AW'(lo_row) * AW'(COLUMNS);
      jb.nfill = CNT_W'(COLUMNS);
    end else if (lo_close) begin
      jb_v     = 1'b1;
      jb.off   = OFF_PC;
      jb.cdst  = AW'(lo_row) * AW'(COLUMNS);
      jb.ncopy = CNT_W'((CNT_W'(ROWS - 1) - CNT_W'(lo_row)) * CNT_W'(COLUMNS));
      jb.fdst  = AW'((ROWS - 1) * COLUMNS);
      jb.nfill = CNT_W'(COLUMNS);
    end

    rd_addr = AW'(read_row_i) * AW'(COLUMNS) + AW'(read_col_i);
    rd_ok   = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    jobb_d      = jobb_q;
    jobb_v_d    = jobb_v_q;
    emit_d      = emit_q;
    dst_d       = dst_q;
    cnt_d       = cnt_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    rd_ok_d     = rd_ok_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    pcr_d       = pcr_q;
    roll_d      = roll_q;
    ins_d       = ins_q;
    phase_d     = phase_q;
    pend_d      = pend_q;
    res_char_d  = res_char_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_char_d  = out_char_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_ins_d   = out_ins_q;
    out_roll_d  = out_roll_q;
    out_busy_d  = out_busy_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          emit_d = 1'b1;
          if (operation_i == OP_READ) begin
            ram_re     = rd_ok;
            ram_raddr  = rd_addr;
            rd_ok_d    = rd_ok;
            state_d    = S_RD;
          end else begin
            cur_col_d  = col_v[COL_W-1:0];
            cur_row_d  = row_v[ROW_W-1:0];
            pcr_d      = n_pcr;
            roll_d     = n_roll;
            ins_d      = n_ins;
            phase_d    = n_phase;
            pend_d     = n_pend;
            res_char_d = '0;
            act_d      = ja;
            jobb_d     = jb;
            jobb_v_d   = jb_v;
            dst_d      = ja.cdst;
            cnt_d      = ja.ncopy;
            wr_pend_d  = 1'b0;
            state_d    = S_COPY;
          end
        end
      end
      S_RD: begin
        res_char_d = rd_ok_q ? ram_rdata : '0;
        state_d    = S_DONE;
      end
      S_COPY: begin
        // Write back the cell read last cycle
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        case (act_q.off)
          OFF_P1:  ram_raddr = dst_q + AW'(1);
          OFF_M1:  ram_raddr = dst_q - AW'(1);
          OFF_PC:  ram_raddr = dst_q + AW'(COLUMNS);
          default: ram_raddr = dst_q - AW'(COLUMNS);
        endcase
        if (cnt_q != '0) begin
          ram_re    = 1'b1;
          wr_pend_d = 1'b1;
          wr_addr_d = dst_q;
          cnt_d     = cnt_q - CNT_W'(1);
          if (act_q.off == OFF_P1 || act_q.off == OFF_PC) begin
            dst_d = dst_q + AW'(1);
          end else begin
            dst_d = dst_q - AW'(1);
          end
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            dst_d   = act_q.fdst;
            cnt_d   = act_q.nfill;
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = SPACE_CHAR;
          dst_d     = dst_q + AW'(1);
          cnt_d     = cnt_q - CNT_W'(1);
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (act_q.put) begin
          ram_we    = 1'b1;
          ram_waddr = act_q.paddr;
          ram_wdata = act_q.pval;
        end
        if (jobb_v_q) begin
          act_d     = jobb_q;
          jobb_v_d  = 1'b0;
          dst_d     = jobb_q.cdst;
          cnt_d     = jobb_q.ncopy;
          wr_pend_d = 1'b0;
          state_d   = S_COPY;
        end else if (emit_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_char_d  = res_char_q;
          out_col_d   = cur_col_q;
          out_row_d   = cur_row_q;
          out_ins_d   = ins_q;
          out_roll_d  = roll_q;
          out_busy_d  = (phase_q != ADDR_NONE);
          emit_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      act_q       <= '0;
      jobb_q      <= '0;
      jobb_v_q    <= 1'b0;
      emit_q      <= 1'b0;
      dst_q       <= '0;
      cnt_q       <= CNT_W'(CELLS);
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      rd_ok_q     <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      pcr_q       <= 1'b0;
      roll_q      <= 1'b0;
      ins_q       <= 1'b0;
      phase_q     <= ADDR_NONE;
      pend_q      <= '0;
      res_char_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_ins_q   <= 1'b0;
      out_roll_q  <= 1'b0;
      out_busy_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      jobb_q      <= jobb_d;
      jobb_v_q    <= jobb_v_d;
      emit_q      <= emit_d;
      dst_q       <= dst_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
      rd_ok_q     <= rd_ok_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      pcr_q       <= pcr_d;
      roll_q      <= roll_d;
      ins_q       <= ins_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      res_char_q  <= res_char_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_ins_q   <= out_ins_d;
      out_roll_q  <= out_roll_d;
      out_busy_q  <= out_busy_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cell_char_o       = out_char_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign insert_mode_on_o  = out_ins_q;
  assign roll_mode_on_o    = out_roll_q;
  assign addressing_busy_o = out_busy_q;

endmodule

`default_nettype wire

@@ hdl/vtsc_ram.sv @@
`default_nettype none

module vtsc_ram #(
  parameter int unsigned Width = 7,
  parameter int unsigned Depth = 1920
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
